>>> rtl/go_to_goal_steering_macros.svh
// assertion macros used by the go-to-goal steering checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef GO_TO_GOAL_STEERING_MACROS_SVH
`define GO_TO_GOAL_STEERING_MACROS_SVH

// same-cycle implication, skipped while in reset
`define GTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while in reset
`define GTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gtg_pkg.sv
// types and constants for the go-to-goal steering block
// no dependencies
package gtg_pkg;

  localparam int unsigned CW = 40;           // cordic x/y datapath
  localparam int unsigned ZW = 33;           // angle accumulator, rad * 2^29
  localparam int unsigned SQRT_STEPS = 16;   // one result bit per cell
  localparam int unsigned ATAN_TABLE_LEN = 24;
  localparam int unsigned PRE_SHIFT = 20;
  localparam int BEARING_LIMIT = 25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314856;

  localparam logic [31:0] ATAN_Q29 [ATAN_TABLE_LEN] = '{
    32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579,
    32'd33510843,  32'd16771758,  32'd8387925,   32'd4194219,
    32'd2097141,   32'd1048575,   32'd524288,    32'd262144,
    32'd131072,    32'd65536,     32'd32768,     32'd16384,
    32'd8192,      32'd4096,      32'd2048,      32'd1024,
    32'd512,       32'd256,       32'd128,       32'd64
  };

  localparam logic [15:0] RST_ARRIVE_RADIUS  = 16'd51;
  localparam logic [31:0] RST_RAD2           = 32'd2601;
  localparam logic [14:0] RST_HEADING_WINDOW = 15'd1638;
  localparam logic [9:0]  RST_CRUISE_SPEED   = 10'd205;
  localparam logic [9:0]  RST_TURN_GAIN      = 10'd256;
  localparam logic [6:0]  PROG_FULL          = 7'd100;

  typedef enum logic [1:0] {
    REG_ARRIVE_RADIUS  = 2'd0,
    REG_HEADING_WINDOW = 2'd1,
    REG_CRUISE_SPEED   = 2'd2,
    REG_TURN_GAIN      = 2'd3
  } gtg_reg_e;

  // word travelling down the cell chain
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [31:0]          rem;
    logic [31:0]          root;
    logic [31:0]          sq;
    logic                 nz;
  } gtg_work_t;

  typedef struct packed {
    logic [31:0] rad2;
    logic [14:0] heading_window;
    logic [9:0]  cruise_speed;
    logic [9:0]  turn_gain;
  } gtg_cfg_t;

endpackage

>>> rtl/go_to_goal_steering.sv
// go-to-goal steering: one word enters per cycle unless in_stall_o is high; the pipeline
// is an entry stage, a chain of cordic/square-root cells (each cell at most one
// micro-rotation and one root bit) and two back-end stages
// a stage only holds while the stage after it is full and held, so bubbles close up
// reset clears every valid bit and loads the register defaults 51, 1638, 205, 256
module go_to_goal_steering import gtg_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] turn_rate_o,
  output logic [9:0]         forward_speed_o,
  output logic [15:0]        goal_range_o,
  output logic signed [15:0] goal_bearing_o,
  output logic [6:0]         progress_pct_o,
  output logic               arrived_o
);

  localparam int unsigned NCELL = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  logic [15:0] arrive_radius_q;
  logic [31:0] rad2_q;
  logic [14:0] heading_window_q;
  logic [9:0]  cruise_speed_q;
  logic [9:0]  turn_gain_q;
  gtg_cfg_t    cfg;

  gtg_work_t   link_w  [NCELL+1];
  logic        link_v  [NCELL+1];
  logic        link_en [NCELL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrive_radius_q  <= RST_ARRIVE_RADIUS;
      heading_window_q <= RST_HEADING_WINDOW;
      cruise_speed_q   <= RST_CRUISE_SPEED;
      turn_gain_q      <= RST_TURN_GAIN;
    end else if (cfg_we_i) begin
      unique case (gtg_reg_e'(cfg_idx_i))
        REG_ARRIVE_RADIUS:  arrive_radius_q  <= cfg_data_i;
        REG_HEADING_WINDOW: heading_window_q <= cfg_data_i[14:0];
        REG_CRUISE_SPEED:   cruise_speed_q   <= cfg_data_i[9:0];
        REG_TURN_GAIN:      turn_gain_q      <= cfg_data_i[9:0];
      endcase
    end
  end

  // squared radius is registered from arrive_radius_q, long before a word reaches the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad2_q <= RST_RAD2;
    end else begin
      rad2_q <= 32'(arrive_radius_q) * 32'(arrive_radius_q);
    end
  end

  assign cfg.rad2           = rad2_q;
  assign cfg.heading_window = heading_window_q;
  assign cfg.cruise_speed   = cruise_speed_q;
  assign cfg.turn_gain      = turn_gain_q;

  gtg_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .goal_x_i   (goal_x_i),
    .goal_y_i   (goal_y_i),
    .en_i       (link_en[0]),
    .valid_o    (link_v[0]),
    .work_o     (link_w[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    gtg_cell #(
      .IDX           (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_v[k]),
      .work_i  (link_w[k]),
      .en_i    (link_en[k+1]),
      .en_o    (link_en[k]),
      .valid_o (link_v[k+1]),
      .work_o  (link_w[k+1])
    );
  end

  gtg_post u_post (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (link_v[NCELL]),
    .work_i          (link_w[NCELL]),
    .cfg_i           (cfg),
    .en_o            (link_en[NCELL]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .turn_rate_o     (turn_rate_o),
    .forward_speed_o (forward_speed_o),
    .goal_range_o    (goal_range_o),
    .goal_bearing_o  (goal_bearing_o),
    .progress_pct_o  (progress_pct_o),
    .arrived_o       (arrived_o)
  );

endmodule

>>> rtl/gtg_prep.sv
// entry stage: squared range and quadrant pre-rotation of the goal
// depends on gtg_pkg
module gtg_prep import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic               en_i,
  output logic               valid_o,
  output gtg_work_t          work_o
);

  logic               valid_q;
  logic               en;
  logic signed [31:0] px, py;
  logic signed [16:0] rx, ry;
  logic signed [ZW-1:0] rz;
  gtg_work_t          work_d, work_q;

  assign en = !valid_q || en_i;
  assign in_stall_o = !en;

  assign px = goal_x_i * goal_x_i;
  assign py = goal_y_i * goal_y_i;

  // goals behind the robot are turned by a quarter turn first
  always_comb begin
    rx = 17'(goal_x_i);
    ry = 17'(goal_y_i);
    rz = '0;
    if (goal_x_i < 0) begin
      if (goal_y_i >= 0) begin
        rx = 17'(goal_y_i);
        ry = -17'(goal_x_i);
        rz = HALF_PI_Q29;
      end else begin
        rx = -17'(goal_y_i);
        ry = 17'(goal_x_i);
        rz = -HALF_PI_Q29;
      end
    end
  end

  always_comb begin
    work_d.x    = CW'(rx) <<< PRE_SHIFT;
    work_d.y    = CW'(ry) <<< PRE_SHIFT;
    work_d.z    = rz;
    work_d.sq   = unsigned'(px) + unsigned'(py);
    work_d.rem  = work_d.sq;
    work_d.root = '0;
    work_d.nz   = (goal_x_i != 16'sd0) || (goal_y_i != 16'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

>>> rtl/gtg_cell.sv
// one cell of the chain: a cordic vectoring micro-rotation and/or one
// bit of the integer square root, as IDX allows; depends on gtg_pkg
module gtg_cell import gtg_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  gtg_work_t work_i,
  input  logic      en_i,
  output logic      en_o,
  output logic      valid_o,
  output gtg_work_t work_o
);

  localparam bit DO_ROT  = IDX < CORDIC_STAGES && IDX < ATAN_TABLE_LEN;
  localparam bit DO_SQRT = IDX < SQRT_STEPS;
  localparam int unsigned ATAN_IDX = DO_ROT ? IDX : 0;
  localparam int unsigned SQ_SH    = DO_SQRT ? 30 - 2 * IDX : 0;
  localparam logic [32:0] SQ_BIT   = 33'(1) << SQ_SH;

  logic                 valid_q;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;
  logic [32:0]          trial;
  gtg_work_t            work_d, work_q;

  assign en_o = !valid_q || en_i;

  always_comb begin
    work_d = work_i;
    dx     = work_i.y >>> IDX;
    dy     = work_i.x >>> IDX;
    ang    = ZW'(ATAN_Q29[ATAN_IDX]);
    trial  = 33'(work_i.root) + SQ_BIT;
    if (DO_ROT) begin
      // drive y towards zero, accumulate the angle turned
      if (work_i.y < 0) begin
        work_d.x = work_i.x - dx;
        work_d.y = work_i.y + dy;
        work_d.z = work_i.z - ang;
      end else begin
        work_d.x = work_i.x + dx;
        work_d.y = work_i.y - dy;
        work_d.z = work_i.z + ang;
      end
    end
    if (DO_SQRT) begin
      if (33'(work_i.rem) >= trial) begin
        work_d.rem  = 32'(33'(work_i.rem) - trial);
        work_d.root = 32'((work_i.root >> 1) + 32'(SQ_BIT));
      end else begin
        work_d.root = work_i.root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

>>> rtl/gtg_post.sv
// back end: bearing rounding, arrival test, progress, turn command
// and the output register; depends on gtg_pkg
module gtg_post import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  gtg_work_t          work_i,
  input  gtg_cfg_t           cfg_i,
  output logic               en_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] turn_rate_o,
  output logic [9:0]         forward_speed_o,
  output logic [15:0]        goal_range_o,
  output logic signed [15:0] goal_bearing_o,
  output logic [6:0]         progress_pct_o,
  output logic               arrived_o
);

  // first stage
  logic                 b1_valid_q;
  logic                 en_out;
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   bear17;
  logic signed [15:0]   bearing_d, bearing_q;
  logic [15:0]          range_d, range_q;
  logic [22:0]          scaled;
  logic [11:0]          cnt;
  logic [6:0]           prog_d, prog_q;
  logic                 far_d, far_q;

  // output stage
  logic signed [26:0]   prod;
  logic signed [18:0]   tr;
  logic signed [15:0]   turn_d;
  logic [15:0]          mag;
  logic                 out_valid_q;
  logic signed [15:0]   turn_q, bearing_out_q;
  logic [9:0]           fwd_d, fwd_q;
  logic [15:0]          range_out_q;
  logic [6:0]           prog_out_d, prog_out_q;
  logic                 arrived_q;

  assign en_out = !out_valid_q || !out_stall_i;
  assign en_o   = !b1_valid_q || en_out;

  always_comb begin
    zr     = work_i.z + ZW'(32768);
    bear17 = 17'(zr >>> 16);
    if (!work_i.nz) begin
      bearing_d = '0;
    end else if (bear17 > 17'(BEARING_LIMIT)) begin
      bearing_d = 16'(BEARING_LIMIT);
    end else if (bear17 < -17'(BEARING_LIMIT)) begin
      bearing_d = -16'(BEARING_LIMIT);
    end else begin
      bearing_d = 16'(bear17);
    end
    range_d = work_i.root[15:0];
    // progress falls by one percent per 2048/100 of range, rounded up
    scaled  = 23'(range_d) * 23'd100 + 23'd2047;
    cnt     = scaled[22:11];
    prog_d  = (cnt >= 12'd100) ? 7'd0 : 7'(12'd100 - cnt);
    far_d   = work_i.sq > cfg_i.rad2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (en_o) begin
      b1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      bearing_q <= bearing_d;
      range_q   <= range_d;
      prog_q    <= prog_d;
      far_q     <= far_d;
    end
  end

  always_comb begin
    prod = $signed({1'b0, cfg_i.turn_gain}) * bearing_q;
    tr   = 19'((prod + 27'sd128) >>> 8);
    mag  = (bearing_q < 0) ? 16'(-bearing_q) : 16'(bearing_q);
    if (!far_q) begin
      turn_d = '0;
    end else if (tr > 19'sd32767) begin
      turn_d = 16'sh7fff;
    end else if (tr < -19'sd32768) begin
      turn_d = 16'sh8000;
    end else begin
      turn_d = 16'(tr);
    end
    fwd_d      = (far_q && mag < {1'b0, cfg_i.heading_window}) ? cfg_i.cruise_speed : '0;
    prog_out_d = far_q ? prog_q : PROG_FULL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      turn_q        <= turn_d;
      fwd_q         <= fwd_d;
      range_out_q   <= range_q;
      bearing_out_q <= bearing_q;
      prog_out_q    <= prog_out_d;
      arrived_q     <= !far_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign turn_rate_o     = turn_q;
  assign forward_speed_o = fwd_q;
  assign goal_range_o    = range_out_q;
  assign goal_bearing_o  = bearing_out_q;
  assign progress_pct_o  = prog_out_q;
  assign arrived_o       = arrived_q;

endmodule

>>> rtl/gtg_checker.sv
// port-level checks on the go-to-goal steering block, bound to the top level
// depends on go_to_goal_steering_macros.svh
`include "go_to_goal_steering_macros.svh"

module gtg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] turn_rate_o,
  input logic [9:0]         forward_speed_o,
  input logic [15:0]        goal_range_o,
  input logic signed [15:0] goal_bearing_o,
  input logic [6:0]         progress_pct_o,
  input logic               arrived_o
);

  // arrival forces a full stop and full progress
  `GTG_ASSERT_NOW(a_arrived_stop, out_valid_o && arrived_o, turn_rate_o == 16'sd0 && forward_speed_o == 10'd0 && progress_pct_o == 7'd100, "arrived word carries motion")

  // two metres or more out means no progress yet
  `GTG_ASSERT_NOW(a_far_progress, out_valid_o && !arrived_o && goal_range_o >= 16'd2048, progress_pct_o == 7'd0, "far goal shows progress")

  `GTG_ASSERT_NOW(a_bearing_bound, out_valid_o, goal_bearing_o <= 16'sd25736 && goal_bearing_o >= -16'sd25736, "bearing beyond pi")

  // non-negative gain keeps the turn on the side of the bearing
  `GTG_ASSERT_NOW(a_turn_sign, out_valid_o && !arrived_o && goal_bearing_o > 16'sd0, turn_rate_o >= 16'sd0, "turn against bearing")

  `GTG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(goal_range_o) && $stable(turn_rate_o), "stalled word changed")

endmodule

bind go_to_goal_steering gtg_checker u_gtg_checker (.*);

>>> sim/go_to_goal_steering_tb.sv
// self-checking testbench for go_to_goal_steering: directed goals, register extremes
// and random goals; each word is checked against a bit-exact steering predictor
// depends on gtg_pkg and the go_to_goal_steering rtl
`timescale 1ns / 100ps

module go_to_goal_steering_tb;
  import gtg_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = 19;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] turn_rate;
    logic [9:0]         forward_speed;
    logic [15:0]        goal_range;
    logic signed [15:0] goal_bearing;
    logic [6:0]         progress_pct;
    logic               arrived;
  } steer_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = REG_ARRIVE_RADIUS;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] goal_x_i = '0;
  logic signed [15:0] goal_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] turn_rate_o;
  logic [9:0]         forward_speed_o;
  logic [15:0]        goal_range_o;
  logic signed [15:0] goal_bearing_o;
  logic [6:0]         progress_pct_o;
  logic               arrived_o;

  // predictor's copy of the registers
  logic [15:0] radius_q = RST_ARRIVE_RADIUS;
  logic [14:0] window_q = RST_HEADING_WINDOW;
  logic [9:0]  cruise_q = RST_CRUISE_SPEED;
  logic [9:0]  gain_q = RST_TURN_GAIN;

  steer_word_t pending_cmds[$];
  int fault_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  go_to_goal_steering #(
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .goal_x_i       (goal_x_i),
    .goal_y_i       (goal_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .turn_rate_o    (turn_rate_o),
    .forward_speed_o(forward_speed_o),
    .goal_range_o   (goal_range_o),
    .goal_bearing_o (goal_bearing_o),
    .progress_pct_o (progress_pct_o),
    .arrived_o      (arrived_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("go_to_goal_steering test failed");
    $finish;
  end

  function automatic steer_word_t steer_predict(input logic signed [15:0] gx,
                                                input logic signed [15:0] gy);
    steer_word_t w;
    longint sq, rad2, root, trial, x, y, z, t, dx, dy, ang, turn, mag, c;
    w = '0;
    w.goal_x = gx;
    w.goal_y = gy;
    x = gx;
    y = gy;
    sq = x * x + y * y;
    rad2 = longint'(radius_q) * longint'(radius_q);
    // floor square root, one bit at a time
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= sq) root = trial;
    end
    // vectoring: drive y to zero, accumulate angle in rad * 2^29
    z = 0;
    if (gx != 0 || gy != 0) begin
      x = x * 1048576;
      y = y * 1048576;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = longint'(HALF_PI_Q29);
        end else begin
          t = x; x = -y; y = t; z = -longint'(HALF_PI_Q29);
        end
      end
      for (int i = 0; i < STAGES && i < ATAN_TABLE_LEN; i++) begin
        ang = ATAN_Q29[i];
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; z -= ang;
        end else begin
          x += dx; y -= dy; z += ang;
        end
      end
      z = (z + 32768) >>> 16;
      if (z > BEARING_LIMIT) z = BEARING_LIMIT;
      if (z < -BEARING_LIMIT) z = -BEARING_LIMIT;
    end
    w.goal_range = root[15:0];
    w.goal_bearing = z[15:0];
    if (sq > rad2) begin
      turn = (longint'(gain_q) * z + 128) >>> 8;
      if (turn > 32767) turn = 32767;
      if (turn < -32768) turn = -32768;
      mag = (z < 0) ? -z : z;
      c = (root * 100 + 2047) / 2048;
      w.turn_rate = turn[15:0];
      w.forward_speed = (mag < longint'(window_q)) ? cruise_q : 10'd0;
      w.progress_pct = (c >= 100) ? 7'd0 : 7'(100 - c);
      w.arrived = 1'b0;
    end else begin
      w.progress_pct = PROG_FULL;
      w.arrived = 1'b1;
    end
    return w;
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_goal(input logic signed [15:0] gx, input logic signed [15:0] gy);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    goal_x_i <= gx;
    goal_y_i <= gy;
    do @(posedge clk_i); while (in_stall_o);
    pending_cmds.push_back(steer_predict(gx, gy));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cmds.size() != 0);
  endtask

  // only called with the block idle
  task automatic write_reg(input gtg_reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ARRIVE_RADIUS:  radius_q = value;
      REG_HEADING_WINDOW: window_q = value[14:0];
      REG_CRUISE_SPEED:   cruise_q = value[9:0];
      REG_TURN_GAIN:      gain_q = value[9:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : result_check
    steer_word_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        log_fault("result word arrived with nothing expected");
      end else begin
        want = pending_cmds.pop_front();
        got = want;
        got.turn_rate = turn_rate_o;
        got.forward_speed = forward_speed_o;
        got.goal_range = goal_range_o;
        got.goal_bearing = goal_bearing_o;
        got.progress_pct = progress_pct_o;
        got.arrived = arrived_o;
        if (got.turn_rate !== want.turn_rate || got.forward_speed !== want.forward_speed ||
            got.goal_range !== want.goal_range || got.goal_bearing !== want.goal_bearing ||
            got.progress_pct !== want.progress_pct || got.arrived !== want.arrived)
          log_fault($sformatf({"goal (%0d,%0d): turn %0d exp %0d, speed %0d exp %0d, ",
                               "range %0d exp %0d, bearing %0d exp %0d, ",
                               "progress %0d exp %0d, arrived %0b exp %0b"},
                              want.goal_x, want.goal_y, got.turn_rate, want.turn_rate,
                              got.forward_speed, want.forward_speed, got.goal_range,
                              want.goal_range, got.goal_bearing, want.goal_bearing,
                              got.progress_pct, want.progress_pct, got.arrived,
                              want.arrived));
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // origin, axes, corners, straight behind, arrival edge, progress edge, heading edge
  task automatic test_special_goals();
    send_goal(0, 0);
    send_goal(51, 0);
    send_goal(51, 1);
    send_goal(36, 36);
    send_goal(-1, 0);
    send_goal(-32768, 0);
    send_goal(32767, 0);
    send_goal(0, 32767);
    send_goal(0, -32768);
    send_goal(-32768, -32768);
    send_goal(32767, 32767);
    send_goal(-32768, 32767);
    send_goal(32767, -32768);
    send_goal(2048, 0);
    send_goal(2027, 0);
    send_goal(10000, 2027);
    send_goal(10000, -2028);
    drain();
  endtask

  // register extremes, with bits above each register's width set to check masking
  task automatic test_register_extremes();
    write_reg(REG_ARRIVE_RADIUS, 16'd0);
    write_reg(REG_HEADING_WINDOW, 16'd0);
    write_reg(REG_CRUISE_SPEED, 16'd1023);
    write_reg(REG_TURN_GAIN, 16'd1023);
    send_goal(0, 0);
    send_goal(1, 0);
    send_goal(-100, 1);
    send_goal(-100, -1);
    drain();
    write_reg(REG_ARRIVE_RADIUS, 16'hffff);
    write_reg(REG_HEADING_WINDOW, 16'hffff);
    write_reg(REG_CRUISE_SPEED, 16'hffff);
    write_reg(REG_TURN_GAIN, 16'd0);
    send_goal(-32768, -32768);
    send_goal(32767, 32767);
    send_goal(-32768, 0);
    drain();
    write_reg(REG_ARRIVE_RADIUS, 16'd100);
    write_reg(REG_HEADING_WINDOW, 16'd25736);
    write_reg(REG_TURN_GAIN, 16'hffff);
    send_goal(-32768, 1);
    send_goal(-32768, 0);
    send_goal(-3000, -40);
    drain();
  endtask

  // random goals; every 250 words the sender waits for all results and the
  // registers get new values
  task automatic test_random_goals(input int send_idle, input int recv_idle, input int count);
    logic signed [15:0] gx, gy, tmp;
    int span;
    int corner_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};
    gap_pct = send_idle;
    stall_pct = recv_idle;
    for (int n = 0; n < count; n++) begin
      if (n % 250 == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_reg(REG_ARRIVE_RADIUS, 16'd0);
          1: write_reg(REG_ARRIVE_RADIUS, 16'($urandom_range(0, 300)));
          2: write_reg(REG_ARRIVE_RADIUS, 16'($urandom_range(0, 4000)));
          default: write_reg(REG_ARRIVE_RADIUS, 16'($urandom));
        endcase
        if ($urandom_range(0, 3) == 0) write_reg(REG_HEADING_WINDOW, 16'($urandom));
        else write_reg(REG_HEADING_WINDOW, 16'($urandom_range(0, BEARING_LIMIT)));
        write_reg(REG_CRUISE_SPEED, 16'($urandom));
        write_reg(REG_TURN_GAIN, 16'($urandom_range(0, 1023)));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          gx = 16'($urandom);
          gy = 16'($urandom);
        end
        4, 5: begin
          gx = clip16(int'($urandom_range(0, 5000)) - 2500);
          gy = clip16(int'($urandom_range(0, 5000)) - 2500);
        end
        6: begin
          // around the arrive circle
          span = int'(radius_q) + 3;
          gx = clip16(int'($urandom_range(0, 2 * span)) - span);
          gy = clip16(int'($urandom_range(0, 2 * span)) - span);
        end
        7: begin
          gx = clip16(int'($urandom_range(0, 2)) - 1);
          gy = 16'($urandom);
          if ($urandom_range(0, 1)) begin
            tmp = gx; gx = gy; gy = tmp;
          end
        end
        8: begin
          gx = 16'(corner_vals[$urandom_range(0, 5)]);
          gy = 16'(corner_vals[$urandom_range(0, 5)]);
        end
        default: begin
          gx = 16'($urandom);
          gy = clip16(int'(gx) + int'($urandom_range(0, 64)) - 32);
        end
      endcase
      send_goal(gx, gy);
    end
    drain();
  endtask

  initial begin : main
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_goals();
    test_register_extremes();
    test_random_goals(26, 51, 630);
    test_random_goals(51, 26, 630);
    test_random_goals(0, 0, 640);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (fault_count == 0 && pending_cmds.size() == 0) begin
      $display("go_to_goal_steering test passed");
    end else begin
      $display("go_to_goal_steering test failed");
    end
    $finish;
  end

endmodule
